[src/bb3_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the 3x3 clipped box blur.
// No dependencies; used by box_blur_3x3_clipped.
package bb3_pkg;

    // Line memory sizing
    localparam int MAX_WIDTH = 1024;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_HEIGHT_W = 16;
    localparam int W_LIMIT = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam int COL_W = (W_LIMIT > 1) ? $clog2(W_LIMIT) : 1;
    localparam logic [CFG_WIDTH_W-1:0] W_LIMIT_CFG = CFG_WIDTH_W'(W_LIMIT);

    // Input row counter runs past the last row of the frame while draining
    localparam int IN_ROW_W = CFG_HEIGHT_W + 1;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

    // Divide by 2*count through a reciprocal multiply
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W = 18;
    localparam int NUM_W = 13;
    localparam int PROD_W = NUM_W + RECIP_W;
    localparam int CSUM_W = 10;
    localparam int SUM_W = 12;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // One window column: three vertically adjacent pixels
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    // One line memory entry: the two rows above the incoming pixel
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_pair_t;

    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } csum_t;

    typedef struct packed {
        logic [NUM_W-1:0] red;
        logic [NUM_W-1:0] green;
        logic [NUM_W-1:0] blue;
    } num_t;

    // Neighbourhood clipping flags for one output pixel
    typedef struct packed {
        logic top_en;
        logic bot_en;
        logic left_en;
        logic right_en;
        logic last;
    } clip_t;

    // ceil(2^RECIP_SHIFT / (2*count)); exact for numerators below 2^NUM_W
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] count);
        logic [RECIP_W-1:0] r;
        unique case (count)
            4'd1:    r = 18'd131072;
            4'd2:    r = 18'd65536;
            4'd3:    r = 18'd43691;
            4'd4:    r = 18'd32768;
            4'd5:    r = 18'd26215;
            4'd6:    r = 18'd21846;
            4'd7:    r = 18'd18725;
            4'd8:    r = 18'd16384;
            4'd9:    r = 18'd14564;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

    // Per-channel sum of one column with the top and bottom rows clipped
    function automatic csum_t col_sum(input column_t c, input logic top_en,
                                      input logic bot_en);
        csum_t s;
        s.red = (top_en ? CSUM_W'(c.top.red) : '0) + CSUM_W'(c.mid.red)
              + (bot_en ? CSUM_W'(c.bot.red) : '0);
        s.green = (top_en ? CSUM_W'(c.top.green) : '0) + CSUM_W'(c.mid.green)
                + (bot_en ? CSUM_W'(c.bot.green) : '0);
        s.blue = (top_en ? CSUM_W'(c.top.blue) : '0) + CSUM_W'(c.mid.blue)
               + (bot_en ? CSUM_W'(c.bot.blue) : '0);
        return s;
    endfunction

endpackage

[src/box_blur_3x3_clipped.sv]
`timescale 1ns / 1ps
// Top level of the 3x3 box blur with border clipping: line memory, window,
// averaging pipeline and frame counters. Depends on bb3_pkg.

// Pixels enter in raster order, one per clock unless stalled, and each result
// is the rounded-half-up mean of the in-image part of its 3x3 neighbourhood.
// Output pixel k leaves on the transfer of input item k+frame_width+1 and
// moves through stages 1 to 3 into the output register; the block takes one
// item per cycle unless stalled, set by the single read-modify-write of the
// line memory (one read and one write port, read data registered, a forwarding
// path for back-to-back accesses to one entry when the row is one pixel wide).
// A stall on the output freezes the whole pipeline, so input stall follows it.
// After the last pixel of the frame, send drain items (func = 1) to flush the
// remaining results; drains before that are dropped, pixels sent while
// draining act as drains. The final result carries last_of_frame, and the
// next item starts a new frame. The line memory needs no clearing after
// reset: entries never written are only read for neighbours that lie outside
// the image and are clipped away. Write frame_width / frame_height only while
// the block is idle; any such write aborts the frame in progress.

module box_blur_3x3_clipped (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [7:0]                      in_blue,
    input  logic [7:0]                      in_green,
    input  logic [7:0]                      in_red,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_blue,
    output logic [7:0]                      out_green,
    output logic [7:0]                      out_red,
    output logic                            last_of_frame
);

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [bb3_pkg::CFG_WIDTH_W-1:0]  frame_width_reg;
    logic [bb3_pkg::CFG_HEIGHT_W-1:0] frame_height_reg;
    logic                             cfg_we;
    logic                             cfg_restart;
    logic [bb3_pkg::CFG_WIDTH_W-1:0]  w_eff;
    logic [bb3_pkg::CFG_HEIGHT_W-1:0] h_eff;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    // Only writes to a known register restart the frame
    assign cfg_restart = cfg_we && ((cfg_index == bb3_pkg::CFG_FRAME_WIDTH)
                                 || (cfg_index == bb3_pkg::CFG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 11'd640;
            frame_height_reg <= 16'd480;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bb3_pkg::CFG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data[bb3_pkg::CFG_WIDTH_W-1:0];
            end
            else if (cfg_index == bb3_pkg::CFG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg_data[bb3_pkg::CFG_HEIGHT_W-1:0];
            end
        end
    end

    // Width of zero acts as one, beyond the line memory acts as its depth
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = 11'd1;
        end
        else if (frame_width_reg > bb3_pkg::W_LIMIT_CFG)
        begin
            w_eff = bb3_pkg::W_LIMIT_CFG;
        end
        else
        begin
            w_eff = frame_width_reg;
        end
        h_eff = (frame_height_reg == '0) ? 16'd1 : frame_height_reg;
    end

    // ---------------------------------------------------------------
    // Handshake: one enable advances every stage
    // ---------------------------------------------------------------
    logic adv;
    logic accept;
    logic take;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // ---------------------------------------------------------------
    // Stage 0: frame counters, clipping flags, line memory read
    // ---------------------------------------------------------------
    logic [bb3_pkg::COL_W-1:0]        in_col_reg, in_col_next;
    logic [bb3_pkg::IN_ROW_W-1:0]     in_row_reg, in_row_next;
    logic [bb3_pkg::COL_W-1:0]        out_col_reg, out_col_next;
    logic [bb3_pkg::CFG_HEIGHT_W-1:0] out_row_reg, out_row_next;

    logic                             drain;
    logic                             emit;
    bb3_pkg::clip_t                   clip;
    logic [1:0]                       rows_used;
    logic [1:0]                       cols_used;
    logic [3:0]                       count;
    logic [bb3_pkg::CFG_WIDTH_W:0]    in_col_inc;
    logic [bb3_pkg::CFG_WIDTH_W:0]    out_col_inc;
    logic                             in_col_wrap;
    logic                             out_col_wrap;
    bb3_pkg::pixel_t                  pix_in;

    assign drain = in_row_reg >= bb3_pkg::IN_ROW_W'(h_eff);
    // Drop drain items that arrive while pixels are still expected
    assign take  = accept && (drain || !func);

    assign emit = ((in_row_reg >= 17'd2) || ((in_row_reg == 17'd1) && (in_col_reg != '0)))
               && (out_row_reg < h_eff);

    assign in_col_inc   = (bb3_pkg::CFG_WIDTH_W + 1)'(in_col_reg) + 12'd1;
    assign out_col_inc  = (bb3_pkg::CFG_WIDTH_W + 1)'(out_col_reg) + 12'd1;
    assign in_col_wrap  = in_col_inc >= (bb3_pkg::CFG_WIDTH_W + 1)'(w_eff);
    assign out_col_wrap = out_col_inc >= (bb3_pkg::CFG_WIDTH_W + 1)'(w_eff);

    always_comb
    begin
        clip.top_en   = out_row_reg != '0;
        clip.bot_en   = (bb3_pkg::IN_ROW_W'(out_row_reg) + 17'd1)
                        < bb3_pkg::IN_ROW_W'(h_eff);
        clip.left_en  = out_col_reg != '0;
        clip.right_en = !out_col_wrap;
        clip.last     = !clip.bot_en && !clip.right_en;
        rows_used     = 2'd1 + 2'(clip.top_en) + 2'(clip.bot_en);
        cols_used     = 2'd1 + 2'(clip.left_en) + 2'(clip.right_en);
        count         = 4'(rows_used) * 4'(cols_used);
    end

    // Pixels sent while draining are not used
    assign pix_in = drain ? '0 : {in_red, in_green, in_blue};

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_restart || (take && emit && clip.last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (take)
        begin
            if (in_col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 17'd1;
            end
            else
            begin
                in_col_next = in_col_inc[bb3_pkg::COL_W-1:0];
            end
            if (emit)
            begin
                if (out_col_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 16'd1;
                end
                else
                begin
                    out_col_next = out_col_inc[bb3_pkg::COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: line memory read-modify-write and window shift
    // ---------------------------------------------------------------
    bb3_pkg::line_pair_t line_mem [bb3_pkg::W_LIMIT];
    bb3_pkg::line_pair_t rd_reg;
    bb3_pkg::line_pair_t fwd_reg;
    bb3_pkg::line_pair_t rows_above;
    bb3_pkg::line_pair_t mem_wdata;

    logic                      s1_valid_reg;
    logic [bb3_pkg::COL_W-1:0] s1_addr_reg;
    bb3_pkg::pixel_t           s1_pix_reg;
    logic                      s1_emit_reg;
    logic                      s1_hit_reg;
    bb3_pkg::clip_t            s1_clip_reg;
    logic [3:0]                s1_count_reg;
    logic                      hit;

    bb3_pkg::column_t          win1_reg;
    bb3_pkg::column_t          win2_reg;
    bb3_pkg::column_t          new_col;
    bb3_pkg::csum_t            sum_left;
    bb3_pkg::csum_t            sum_centre;
    bb3_pkg::csum_t            sum_right;

    // The entry written at this edge is read at the same edge: forward it
    assign hit = s1_valid_reg && (s1_addr_reg == in_col_reg);

    assign rows_above = s1_hit_reg ? fwd_reg : rd_reg;
    assign new_col    = '{top: rows_above.upper, mid: rows_above.middle, bot: s1_pix_reg};
    // Shift the column down one row
    assign mem_wdata  = '{upper: rows_above.middle, middle: s1_pix_reg};

    always_ff @(posedge clk)
    begin
        if (adv && take)
        begin
            rd_reg <= line_mem[in_col_reg];
        end
        if (adv && s1_valid_reg)
        begin
            line_mem[s1_addr_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_addr_reg  <= in_col_reg;
            s1_pix_reg   <= pix_in;
            s1_emit_reg  <= emit;
            s1_hit_reg   <= hit;
            s1_clip_reg  <= clip;
            s1_count_reg <= count;
            fwd_reg      <= mem_wdata;
        end
        if (adv && s1_valid_reg)
        begin
            win1_reg <= win2_reg;
            win2_reg <= new_col;
        end
    end

    // The centre column is always the newer of the two held columns; the
    // incoming column is the right neighbour
    assign sum_left   = s1_clip_reg.left_en
                      ? bb3_pkg::col_sum(win1_reg, s1_clip_reg.top_en, s1_clip_reg.bot_en)
                      : '0;
    assign sum_centre = bb3_pkg::col_sum(win2_reg, s1_clip_reg.top_en, s1_clip_reg.bot_en);
    assign sum_right  = s1_clip_reg.right_en
                      ? bb3_pkg::col_sum(new_col, s1_clip_reg.top_en, s1_clip_reg.bot_en)
                      : '0;

    // ---------------------------------------------------------------
    // Stage 2: total sum and rounding numerator 2*sum + count
    // ---------------------------------------------------------------
    logic                 s2_valid_reg;
    logic                 s2_last_reg;
    logic [3:0]           s2_count_reg;
    bb3_pkg::csum_t       s2_left_reg;
    bb3_pkg::csum_t       s2_centre_reg;
    bb3_pkg::csum_t       s2_right_reg;
    logic [bb3_pkg::SUM_W-1:0] sum_red;
    logic [bb3_pkg::SUM_W-1:0] sum_green;
    logic [bb3_pkg::SUM_W-1:0] sum_blue;
    bb3_pkg::num_t        numer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_last_reg   <= s1_clip_reg.last;
            s2_count_reg  <= s1_count_reg;
            s2_left_reg   <= sum_left;
            s2_centre_reg <= sum_centre;
            s2_right_reg  <= sum_right;
        end
    end

    always_comb
    begin
        sum_red   = bb3_pkg::SUM_W'(s2_left_reg.red) + bb3_pkg::SUM_W'(s2_centre_reg.red)
                  + bb3_pkg::SUM_W'(s2_right_reg.red);
        sum_green = bb3_pkg::SUM_W'(s2_left_reg.green) + bb3_pkg::SUM_W'(s2_centre_reg.green)
                  + bb3_pkg::SUM_W'(s2_right_reg.green);
        sum_blue  = bb3_pkg::SUM_W'(s2_left_reg.blue) + bb3_pkg::SUM_W'(s2_centre_reg.blue)
                  + bb3_pkg::SUM_W'(s2_right_reg.blue);
        numer.red   = {sum_red, 1'b0} + bb3_pkg::NUM_W'(s2_count_reg);
        numer.green = {sum_green, 1'b0} + bb3_pkg::NUM_W'(s2_count_reg);
        numer.blue  = {sum_blue, 1'b0} + bb3_pkg::NUM_W'(s2_count_reg);
    end

    // ---------------------------------------------------------------
    // Stage 3: divide by 2*count through the reciprocal
    // ---------------------------------------------------------------
    logic                          s3_valid_reg;
    logic                          s3_last_reg;
    bb3_pkg::num_t                 s3_numer_reg;
    logic [bb3_pkg::RECIP_W-1:0]   s3_recip_reg;
    logic [bb3_pkg::PROD_W-1:0]    prod_red;
    logic [bb3_pkg::PROD_W-1:0]    prod_green;
    logic [bb3_pkg::PROD_W-1:0]    prod_blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_last_reg  <= s2_last_reg;
            s3_numer_reg <= numer;
            s3_recip_reg <= bb3_pkg::recip(s2_count_reg);
        end
    end

    assign prod_red   = bb3_pkg::PROD_W'(s3_numer_reg.red) * bb3_pkg::PROD_W'(s3_recip_reg);
    assign prod_green = bb3_pkg::PROD_W'(s3_numer_reg.green) * bb3_pkg::PROD_W'(s3_recip_reg);
    assign prod_blue  = bb3_pkg::PROD_W'(s3_numer_reg.blue) * bb3_pkg::PROD_W'(s3_recip_reg);

    // ---------------------------------------------------------------
    // Output register: hold while stalled
    // ---------------------------------------------------------------
    bb3_pkg::pixel_t out_pix_reg;
    logic            out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pix_reg.red   <= prod_red[bb3_pkg::RECIP_SHIFT+7:bb3_pkg::RECIP_SHIFT];
            out_pix_reg.green <= prod_green[bb3_pkg::RECIP_SHIFT+7:bb3_pkg::RECIP_SHIFT];
            out_pix_reg.blue  <= prod_blue[bb3_pkg::RECIP_SHIFT+7:bb3_pkg::RECIP_SHIFT];
            out_last_reg      <= s3_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_red       = out_pix_reg.red;
    assign out_green     = out_pix_reg.green;
    assign out_blue      = out_pix_reg.blue;
    assign last_of_frame = out_last_reg;

endmodule
